[rtl/rsi_pkg.sv]
package rsi_pkg;

    // default geometry
    localparam int COORD_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // tangent tolerance register
    localparam int          TOL_W     = 17;
    localparam logic [16:0] TOL_RESET = 17'd1;

    // digit size of the pipelined multipliers
    localparam int DIGIT_W = 32;

    typedef enum logic [1:0] {
        ST_DISJOINT = 2'd0,
        ST_TANGENT  = 2'd1,
        ST_CROSS    = 2'd2,
        ST_ZERO_DIR = 2'd3
    } t_status;

endpackage

[rtl/ray_sphere_intersection_core.sv]
// Throughput: one ray per cycle unless the output stalls; the square-root chain
// (one root bit per stage) and the two dividers (one quotient bit per
// stage) set the depth.
// The whole pipeline advances together; it holds while a result waits at the output.
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the tolerance to 1.
module ray_sphere_intersection_core #(
    parameter int COORD_WIDTH   = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [rsi_pkg::TOL_W-1:0]   i_cfg_data,
    // ray input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [COORD_WIDTH-1:0]      i_origin_x,
    input  logic [COORD_WIDTH-1:0]      i_origin_y,
    input  logic [COORD_WIDTH-1:0]      i_origin_z,
    input  logic [COORD_WIDTH-1:0]      i_direction_x,
    input  logic [COORD_WIDTH-1:0]      i_direction_y,
    input  logic [COORD_WIDTH-1:0]      i_direction_z,
    input  logic [COORD_WIDTH-1:0]      i_center_x,
    input  logic [COORD_WIDTH-1:0]      i_center_y,
    input  logic [COORD_WIDTH-1:0]      i_center_z,
    input  logic [COORD_WIDTH-2:0]      i_radius,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_status,
    output logic [COORD_WIDTH-1:0]      o_t_near,
    output logic [COORD_WIDTH-1:0]      o_t_far,
    output logic [COORD_WIDTH-1:0]      o_near_x,
    output logic [COORD_WIDTH-1:0]      o_near_y,
    output logic [COORD_WIDTH-1:0]      o_near_z,
    output logic [COORD_WIDTH-1:0]      o_far_x,
    output logic [COORD_WIDTH-1:0]      o_far_y,
    output logic [COORD_WIDTH-1:0]      o_far_z
);

    localparam int CW   = COORD_WIDTH;
    localparam int FB   = FRACTION_BITS;
    localparam int EW   = CW + 1;          // o - c
    localparam int WA   = 2 * CW + 2;      // A = d.d
    localparam int WB   = 2 * CW + 3;      // B = d.e (half b)
    localparam int WC   = 2 * CW + 4;      // C = e.e - r*r
    localparam int HW   = 4 * CW + 8;      // quarter discriminant
    localparam int SW   = HW / 2;          // its root
    localparam int NW   = SW + 2;          // -B -+ S
    localparam int MW   = NW + FB;         // scaled numerator magnitude
    localparam int DVW  = WA - 1;          // divisor, A is never negative
    localparam int SUMW = ((2 * CW - FB > CW) ? 2 * CW - FB : CW) + 1;
    localparam int TOLW = rsi_pkg::TOL_W;
    localparam int CMPW = (SW > TOLW + FB) ? SW : TOLW + FB;

    // pipeline timing, in cycles after the input transfer
    localparam int T_S   = 9 + SW;         // root ready
    localparam int T_D   = T_S + 2 + CW;   // quotients ready
    localparam int T_OUT = T_D + 5;        // output register

    localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};
    localparam logic [CW:0]   HALF = (CW+1)'(1) << (CW - 1);

    // ---------------------------------------------------------------
    // flow control: one global advance for every stage
    // ---------------------------------------------------------------
    logic                 en;
    logic [T_OUT-1:0]     r_vld;
    logic [TOLW-1:0]      r_tol;

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[T_OUT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[T_OUT-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= rsi_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // T1: capture, e = o - c
    // ---------------------------------------------------------------
    logic signed [CW-1:0] in_o [3];
    logic signed [CW-1:0] in_d [3];
    logic signed [CW-1:0] in_c [3];
    logic signed [CW-1:0] r_o  [3];
    logic signed [CW-1:0] r_d  [3];
    logic signed [EW-1:0] r_e  [3];
    logic signed [CW-1:0] r_r;

    assign in_o[0] = $signed(i_origin_x);
    assign in_o[1] = $signed(i_origin_y);
    assign in_o[2] = $signed(i_origin_z);
    assign in_d[0] = $signed(i_direction_x);
    assign in_d[1] = $signed(i_direction_y);
    assign in_d[2] = $signed(i_direction_z);
    assign in_c[0] = $signed(i_center_x);
    assign in_c[1] = $signed(i_center_y);
    assign in_c[2] = $signed(i_center_z);

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_o[i] <= in_o[i];
                r_d[i] <= in_d[i];
                r_e[i] <= EW'(in_o[i]) - EW'(in_c[i]);
            end
            r_r <= $signed({1'b0, i_radius});
        end
    end

    // ---------------------------------------------------------------
    // T1..T4: dot products, squared radius
    // ---------------------------------------------------------------
    logic signed [2*CW-1:0]   p_dd [3];
    logic signed [2*CW:0]     p_de [3];
    logic signed [2*CW+1:0]   p_ee [3];
    logic signed [2*CW-1:0]   p_rr;

    for (genvar i = 0; i < 3; i++) begin : g_dot
        rsi_mul #(.AW(CW), .BW(CW)) u_dd (
            .i_clk(i_clk), .i_en(en), .i_a(r_d[i]), .i_b(r_d[i]), .o_p(p_dd[i])
        );
        rsi_mul #(.AW(CW), .BW(EW)) u_de (
            .i_clk(i_clk), .i_en(en), .i_a(r_d[i]), .i_b(r_e[i]), .o_p(p_de[i])
        );
        rsi_mul #(.AW(EW), .BW(EW)) u_ee (
            .i_clk(i_clk), .i_en(en), .i_a(r_e[i]), .i_b(r_e[i]), .o_p(p_ee[i])
        );
    end

    rsi_mul #(.AW(CW), .BW(CW)) u_rr (
        .i_clk(i_clk), .i_en(en), .i_a(r_r), .i_b(r_r), .o_p(p_rr)
    );

    // T5: A, B, C
    logic signed [WA-1:0] r_a;
    logic signed [WB-1:0] r_b;
    logic signed [WC-1:0] r_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= WA'(p_dd[0]) + WA'(p_dd[1]) + WA'(p_dd[2]);
            r_b <= WB'(p_de[0]) + WB'(p_de[1]) + WB'(p_de[2]);
            r_c <= WC'(p_ee[0]) + WC'(p_ee[1]) + WC'(p_ee[2]) - WC'(p_rr);
        end
    end

    // T5..T8: B*B and A*C
    logic signed [2*WB-1:0]  p_bb;
    logic signed [WA+WC-1:0] p_ac;

    rsi_mul #(.AW(WB), .BW(WB)) u_bb (
        .i_clk(i_clk), .i_en(en), .i_a(r_b), .i_b(r_b), .o_p(p_bb)
    );
    rsi_mul #(.AW(WA), .BW(WC)) u_ac (
        .i_clk(i_clk), .i_en(en), .i_a(r_a), .i_b(r_c), .o_p(p_ac)
    );

    logic [WA-1:0] a_d8;
    logic [WA-1:0] a_ts1;
    logic [WB-1:0] b_ts;

    rsi_dly #(.W(WA), .N(3))      u_dly_a8  (.i_clk(i_clk), .i_en(en), .i_d(r_a),  .o_q(a_d8));
    rsi_dly #(.W(WA), .N(SW + 2)) u_dly_ad  (.i_clk(i_clk), .i_en(en), .i_d(a_d8), .o_q(a_ts1));
    rsi_dly #(.W(WB), .N(SW + 4)) u_dly_b   (.i_clk(i_clk), .i_en(en), .i_d(r_b),  .o_q(b_ts));

    // T9: discriminant and special cases
    logic signed [HW-1:0] n_h;
    logic [HW-1:0]        r_h;
    logic                 r_hneg;
    logic                 r_zdir;

    assign n_h = HW'(p_bb) - HW'(p_ac);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h    <= n_h;
            r_hneg <= n_h[HW-1];
            r_zdir <= (a_d8 == '0);
        end
    end

    // T9..T_S: root; a negative discriminant gives a root that is never used
    logic [SW-1:0] s_root;
    logic [1:0]    flg_ts;

    rsi_sqrt #(.HW(HW)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_h(r_h), .o_s(s_root)
    );

    rsi_dly #(.W(2), .N(SW)) u_dly_flg (
        .i_clk(i_clk), .i_en(en), .i_d({r_zdir, r_hneg}), .o_q(flg_ts)
    );

    // ---------------------------------------------------------------
    // T_S+1: numerators -B -+ S, their sign and magnitude, status
    // ---------------------------------------------------------------
    logic signed [NW-1:0] num_n;
    logic signed [NW-1:0] num_f;
    logic [NW-1:0]        mag_n;
    logic [NW-1:0]        mag_f;
    logic [CMPW-1:0]      tol_sh;
    logic                 tangent;
    rsi_pkg::t_status     n_status;
    logic [MW-1:0]        r_mn;
    logic [MW-1:0]        r_mf;
    logic                 r_sn;
    logic                 r_sf;
    rsi_pkg::t_status     r_status;

    always_comb begin
        num_n   = -NW'($signed(b_ts)) - NW'($signed({1'b0, s_root}));
        num_f   = -NW'($signed(b_ts)) + NW'($signed({1'b0, s_root}));
        mag_n   = num_n[NW-1] ? NW'(-num_n) : NW'(num_n);
        mag_f   = num_f[NW-1] ? NW'(-num_f) : NW'(num_f);
        tol_sh  = CMPW'(r_tol) << (FB - 1);
        tangent = (CMPW'(s_root) < tol_sh);
        if (flg_ts[1]) begin
            n_status = rsi_pkg::ST_ZERO_DIR;
        end else if (flg_ts[0]) begin
            n_status = rsi_pkg::ST_DISJOINT;
        end else if (tangent) begin
            n_status = rsi_pkg::ST_TANGENT;
        end else begin
            n_status = rsi_pkg::ST_CROSS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mn     <= {mag_n, {FB{1'b0}}};
            r_mf     <= {mag_f, {FB{1'b0}}};
            r_sn     <= num_n[NW-1];
            r_sf     <= num_f[NW-1];
            r_status <= n_status;
        end
    end

    // T_S+1..T_D: |num| / A
    logic [CW-1:0] quo  [2];
    logic          qovf [2];
    logic          qrnz [2];
    logic [1:0]    sgn_td;

    rsi_div #(.MW(MW), .VW(DVW), .QW(CW)) u_div_n (
        .i_clk(i_clk), .i_en(en), .i_num(r_mn), .i_den(a_ts1[DVW-1:0]),
        .o_quo(quo[0]), .o_ovf(qovf[0]), .o_rnz(qrnz[0])
    );
    rsi_div #(.MW(MW), .VW(DVW), .QW(CW)) u_div_f (
        .i_clk(i_clk), .i_en(en), .i_num(r_mf), .i_den(a_ts1[DVW-1:0]),
        .o_quo(quo[1]), .o_ovf(qovf[1]), .o_rnz(qrnz[1])
    );

    rsi_dly #(.W(2), .N(CW + 1)) u_dly_sgn (
        .i_clk(i_clk), .i_en(en), .i_d({r_sf, r_sn}), .o_q(sgn_td)
    );

    // T_D+1: floor toward minus infinity and saturate
    logic [CW:0]          qp    [2];
    logic signed [CW-1:0] n_t   [2];
    logic signed [CW-1:0] r_t   [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            qp[k] = {1'b0, quo[k]} + (CW+1)'(qrnz[k]);
            if (!sgn_td[k]) begin
                n_t[k] = (qovf[k] || quo[k][CW-1]) ? MAXV : quo[k];
            end else begin
                n_t[k] = (qovf[k] || (qp[k] > HALF)) ? MINV : CW'(-qp[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t[0] <= n_t[0];
            r_t[1] <= n_t[1];
        end
    end

    // ---------------------------------------------------------------
    // T_D+1..T_D+4: hit points o + (d*t >>> FB)
    // ---------------------------------------------------------------
    logic [3*CW-1:0] o_pk;
    logic [3*CW-1:0] d_pk;
    logic [3*CW-1:0] o_hit;
    logic [3*CW-1:0] d_hit;
    logic [2*CW-1:0] t_hit;
    logic [1:0]      st_hit;
    logic signed [2*CW-1:0] p_hit [2][3];

    assign o_pk = {r_o[2], r_o[1], r_o[0]};
    assign d_pk = {r_d[2], r_d[1], r_d[0]};

    rsi_dly #(.W(3*CW), .N(T_D + 3)) u_dly_o (
        .i_clk(i_clk), .i_en(en), .i_d(o_pk), .o_q(o_hit)
    );
    rsi_dly #(.W(3*CW), .N(T_D)) u_dly_d (
        .i_clk(i_clk), .i_en(en), .i_d(d_pk), .o_q(d_hit)
    );
    rsi_dly #(.W(2*CW), .N(3)) u_dly_t (
        .i_clk(i_clk), .i_en(en), .i_d({r_t[1], r_t[0]}), .o_q(t_hit)
    );
    rsi_dly #(.W(2), .N(CW + 5)) u_dly_st (
        .i_clk(i_clk), .i_en(en), .i_d(r_status), .o_q(st_hit)
    );

    for (genvar k = 0; k < 2; k++) begin : g_hit_t
        for (genvar i = 0; i < 3; i++) begin : g_hit_ax
            rsi_mul #(.AW(CW), .BW(CW)) u_hit (
                .i_clk(i_clk), .i_en(en),
                .i_a($signed(d_hit[CW*i +: CW])), .i_b($signed(r_t[k])),
                .o_p(p_hit[k][i])
            );
        end
    end

    // T_OUT: sum, saturate, zero the fields of the no-hit cases
    logic signed [SUMW-1:0] sum   [2][3];
    logic [CW-1:0]          n_pt  [2][3];
    logic [SUMW-CW:0]       hi    [2][3];
    logic                   nohit;
    rsi_pkg::t_status       st_fin;
    logic [CW-1:0]          r_pt  [2][3];
    logic [CW-1:0]          r_tn;
    logic [CW-1:0]          r_tf;
    rsi_pkg::t_status       r_out_status;

    always_comb begin
        st_fin = rsi_pkg::t_status'(st_hit);
        nohit  = (st_fin == rsi_pkg::ST_DISJOINT) || (st_fin == rsi_pkg::ST_ZERO_DIR);
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 3; i++) begin
                sum[k][i] = SUMW'($signed(o_hit[CW*i +: CW]))
                          + SUMW'(p_hit[k][i] >>> FB);
                hi[k][i]  = sum[k][i][SUMW-1:CW-1];
                if ((hi[k][i] == '0) || (hi[k][i] == '1)) begin
                    n_pt[k][i] = sum[k][i][CW-1:0];
                end else begin
                    n_pt[k][i] = sum[k][i][SUMW-1] ? MINV : MAXV;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_status <= st_fin;
            r_tn <= nohit ? '0 : t_hit[CW-1:0];
            r_tf <= nohit ? '0 : t_hit[2*CW-1:CW];
            for (int k = 0; k < 2; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pt[k][i] <= nohit ? '0 : n_pt[k][i];
                end
            end
        end
    end

    assign o_status = r_out_status;
    assign o_t_near = r_tn;
    assign o_t_far  = r_tf;
    assign o_near_x = r_pt[0][0];
    assign o_near_y = r_pt[0][1];
    assign o_near_z = r_pt[0][2];
    assign o_far_x  = r_pt[1][0];
    assign o_far_y  = r_pt[1][1];
    assign o_far_z  = r_pt[1][2];

`ifndef NO_ASSERTIONS
    // no result leaves a pipeline that reset has just emptied
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a miss or a zero direction carries no ray parameters
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == rsi_pkg::ST_DISJOINT) ||
                        (o_status == rsi_pkg::ST_ZERO_DIR))
        |-> (o_t_near == '0) && (o_t_far == '0))
        else $error("nonzero t on a miss");

    // near root never beyond far root
    a_t_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == rsi_pkg::ST_TANGENT) ||
                        (o_status == rsi_pkg::ST_CROSS))
        |-> ($signed(o_t_near) <= $signed(o_t_far)))
        else $error("t_near above t_far");
`endif

endmodule

[rtl/rsi_dly.sv]
module rsi_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[N-1];

endmodule

[rtl/rsi_mul.sv]
// Signed multiplier, three stages: magnitudes, digit partial products, sum and sign.
module rsi_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int DW  = rsi_pkg::DIGIT_W;
    localparam int NA  = (AW + DW - 1) / DW;
    localparam int NB  = (BW + DW - 1) / DW;
    localparam int PW  = (NA + NB) * DW;

    logic [AW-1:0]      abs_a;
    logic [BW-1:0]      abs_b;
    logic [NA*DW-1:0]   r_ma;
    logic [NB*DW-1:0]   r_mb;
    logic               r_neg1;
    logic               r_neg2;
    logic [2*DW-1:0]    r_pp [NA][NB];
    logic [PW-1:0]      acc;
    logic [AW+BW-1:0]   n_p;
    logic [AW+BW-1:0]   r_p;

    assign abs_a = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign abs_b = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= (NA*DW)'(abs_a);
            r_mb   <= (NB*DW)'(abs_b);
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg2 <= r_neg1;
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_ma[DW*i +: DW] * r_mb[DW*j +: DW];
                end
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                acc = acc + (PW'(r_pp[i][j]) << (DW * (i + j)));
            end
        end
        n_p = r_neg2 ? (AW+BW)'(-acc) : (AW+BW)'(acc);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = $signed(r_p);

endmodule

[rtl/rsi_sqrt.sv]
// Integer square root, one result bit per stage.
module rsi_sqrt #(
    parameter int HW = 136
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [HW-1:0]     i_h,
    output logic [HW/2-1:0]   o_s
);

    localparam int SW = HW / 2;

    logic [HW-1:0] r_rem  [SW-1];
    logic [SW-1:0] r_root [SW];

    for (genvar k = 0; k < SW; k++) begin : g_stage
        localparam int BIT = SW - 1 - k;
        logic [HW-1:0] rem_in;
        logic [SW-1:0] root_in;
        logic [HW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in  = i_h;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        assign trial = (HW'(root_in) << (BIT + 1)) | (HW'(1) << (2 * BIT));
        assign take  = (rem_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= take ? (root_in | (SW'(1) << BIT)) : root_in;
            end
        end

        if (k < SW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? (rem_in - trial) : rem_in;
                end
            end
        end
    end

    assign o_s = r_root[SW-1];

endmodule

[rtl/rsi_div.sv]
// Unsigned restoring divider, one quotient bit per stage, with overflow flag
// for quotients of more than QW bits.
module rsi_div #(
    parameter int MW = 86,
    parameter int VW = 65,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [MW-1:0] i_num,
    input  logic [VW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic          o_ovf,
    output logic          o_rnz
);

    localparam int DW = ((MW > VW + QW) ? MW : VW + QW) + 1;

    logic [DW-1:0] r_rem [QW+1];
    logic [VW-1:0] r_den [QW];
    logic          r_ovf [QW+1];
    logic [QW-1:0] r_q   [1:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num);
            r_den[0] <= i_den;
            r_ovf[0] <= (DW'(i_num) >= (DW'(i_den) << QW));
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int BIT = QW - k;
        logic [QW-1:0] q_in;
        logic [DW-1:0] sh;
        logic          take;

        if (k == 1) begin : g_first
            assign q_in = '0;
        end else begin : g_next
            assign q_in = r_q[k-1];
        end

        assign sh   = DW'(r_den[k-1]) << BIT;
        assign take = (r_rem[k-1] >= sh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= take ? (r_rem[k-1] - sh) : r_rem[k-1];
                r_q[k]   <= take ? (q_in | (QW'(1) << BIT)) : q_in;
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < QW) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quo = r_q[QW];
    assign o_ovf = r_ovf[QW];
    assign o_rnz = |r_rem[QW];

endmodule
